>>> sv/multi_console_line_editor_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-console line editor
// Short forms for clocked implications under the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH
`define MULTI_CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mcle_pkg.sv
// ----------------------------------------------------------------------------
// mcle_pkg
// Key codes, command, status and state codes and default sizes for the line editor.
// ----------------------------------------------------------------------------
package mcle_pkg;

	// Default sizes.
	localparam int BUFFER_DEPTH_DEF  = 128;
	localparam int CONSOLE_COUNT_DEF = 10;

	// Saturation limit of the erase counter.
	localparam logic [7:0] ERASE_MAX = 8'd255;

	// Key codes.
	localparam logic [7:0] KEY_NUL  = 8'h00;
	localparam logic [7:0] KEY_LF   = 8'h0A;
	localparam logic [7:0] KEY_CR   = 8'h0D;
	localparam logic [7:0] KEY_DEL  = 8'h7F;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_KILL = 8'h15;
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_NEXT = 8'h0E;
	localparam logic [7:0] KEY_PREV = 8'h02;
	localparam logic [7:0] KEY_DUMP = 8'h10;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Read status codes.
	typedef enum logic [1:0] {
		RS_NONE  = 2'd0,
		RS_DATA  = 2'd1,
		RS_EOF   = 2'd2,
		RS_EMPTY = 2'd3
	} read_status_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

endpackage

>>> sv/mcle_line_mem.sv
// ----------------------------------------------------------------------------
// mcle_line_mem
// Line store of all consoles: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mcle_line_mem #(
	parameter int DEPTH = mcle_pkg::BUFFER_DEPTH_DEF * mcle_pkg::CONSOLE_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/multi_console_line_editor_unit.sv
// ----------------------------------------------------------------------------
// multi_console_line_editor_unit
// Canonical line editing over several virtual consoles, one ring per console.
// ----------------------------------------------------------------------------
// One word is taken, then executed: the accept cycle issues the line store read,
// and the execute state uses the read data and updates the indices. A kill-line
// key stays in the execute state while it walks the ring backwards, one memory
// read per character erased. The execute state waits to finish while the output
// register still holds an untaken word. There is no clearing pass after reset:
// only entries already written are ever read.
`include "multi_console_line_editor_unit_assert.svh"

module multi_console_line_editor_unit #(
	parameter int BUFFER_DEPTH  = mcle_pkg::BUFFER_DEPTH_DEF,
	parameter int CONSOLE_COUNT = mcle_pkg::CONSOLE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// Input channel.
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	input  logic [3:0] console,
	input  logic       first_of_read,
	// Output channel.
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] read_status,
	output logic [7:0] read_byte,
	output logic       line_end,
	output logic       echo_valid,
	output logic [7:0] echo_byte,
	output logic [7:0] erase_count,
	output logic       line_committed,
	output logic [3:0] active_console,
	output logic       console_switched
);

	localparam int SPAN   = 2 * BUFFER_DEPTH;
	localparam int IW     = $clog2(SPAN);
	localparam int DW     = IW + 1;
	localparam int MDEPTH = CONSOLE_COUNT * BUFFER_DEPTH;
	localparam int AW     = $clog2(MDEPTH);
	localparam int CW     = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;

	// Ring slot address of an index of a console.
	function automatic logic [AW-1:0] slot_f(input logic [CW-1:0] con,
						 input logic [IW-1:0] idx);
		logic [IW-1:0] p;
		logic [AW-1:0] base;
		p    = (idx >= IW'(BUFFER_DEPTH)) ? idx - IW'(BUFFER_DEPTH) : idx;
		base = AW'(con) * AW'(BUFFER_DEPTH);
		return base + AW'(p);
	endfunction

	function automatic logic [IW-1:0] inc_f(input logic [IW-1:0] idx);
		return (idx == IW'(SPAN - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [IW-1:0] dec_f(input logic [IW-1:0] idx);
		return (idx == '0) ? IW'(SPAN - 1) : idx - 1'b1;
	endfunction

	function automatic logic [DW-1:0] diff_f(input logic [IW-1:0] a, input logic [IW-1:0] b);
		return (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + DW'(SPAN) - {1'b0, b};
	endfunction

	mcle_pkg::state_t state_q, state_d;

	// Per-console indices and the active console.
	logic [IW-1:0] read_idx_q   [CONSOLE_COUNT];
	logic [IW-1:0] commit_idx_q [CONSOLE_COUNT];
	logic [IW-1:0] edit_idx_q   [CONSOLE_COUNT];
	logic [CW-1:0] cur_q, cur_d;

	// Word held during execution.
	mcle_pkg::cmd_t cmd_q;
	logic [7:0]     byte_q;
	logic [3:0]     con_q;
	logic           con_ok_q;
	logic [CW-1:0]  cidx_q;
	logic           first_q;
	logic [7:0]     cnt_q, cnt_d;

	// Input side decode.
	logic          accept;
	logic          con_ok_in;
	logic [CW-1:0] cidx_in;

	// Entry under update.
	logic [CW-1:0] sel;
	logic [IW-1:0] rd_c, cm_c, ed_c;
	logic [IW-1:0] rd_n, cm_n, ed_n;
	logic          upd;
	logic [DW-1:0] occ_c;
	logic [7:0]    store_c;
	logic [IW-1:0] ed_inc;

	// Memory ports.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata;

	// Output register.
	logic                     out_free, o_load;
	mcle_pkg::read_status_t   rs_d;
	logic [7:0]               rb_d, eb_d, ec_d;
	logic                     le_d, ev_d, lc_d, sw_d;
	logic                     out_valid_q;
	logic [1:0]               read_status_q;
	logic [7:0]               read_byte_q, echo_byte_q, erase_count_q;
	logic                     line_end_q, echo_valid_q, line_committed_q, switched_q;
	logic [3:0]               active_q;

	mcle_line_mem #(
		.DEPTH (MDEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (store_c),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Input decode and selection of the console entry being worked on.
	assign accept    = in_valid && !in_stall;
	assign con_ok_in = {1'b0, console} < 5'(CONSOLE_COUNT);
	assign cidx_in   = con_ok_in ? CW'(console) : '0;
	assign sel       = (cmd_q == mcle_pkg::CMD_KEY) ? cur_q : cidx_q;
	assign rd_c      = read_idx_q[sel];
	assign cm_c      = commit_idx_q[sel];
	assign ed_c      = edit_idx_q[sel];
	assign occ_c     = diff_f(ed_c, rd_c);
	assign ed_inc    = inc_f(ed_c);
	assign store_c   = (byte_q == mcle_pkg::KEY_CR) ? mcle_pkg::KEY_LF : byte_q;
	assign mem_waddr = slot_f(cur_q, ed_c);
	assign out_free  = !out_valid_q || !out_stall;

	// Next state, index updates, memory accesses and the result word.
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != mcle_pkg::ST_IDLE);
		cur_d    = cur_q;
		cnt_d    = cnt_q;
		rd_n     = rd_c;
		cm_n     = cm_c;
		ed_n     = ed_c;
		upd      = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_raddr = '0;
		o_load   = 1'b0;
		rs_d     = mcle_pkg::RS_NONE;
		rb_d     = '0;
		le_d     = 1'b0;
		ev_d     = 1'b0;
		eb_d     = '0;
		ec_d     = '0;
		lc_d     = 1'b0;
		sw_d     = 1'b0;
		unique case (state_q)
			mcle_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mcle_pkg::ST_EXEC;
					mem_re  = 1'b1;
					if (mcle_pkg::cmd_t'(cmd) == mcle_pkg::CMD_READ) begin
						mem_raddr = slot_f(cidx_in, read_idx_q[cidx_in]);
					end else begin
						mem_raddr = slot_f(cur_q, dec_f(edit_idx_q[cur_q]));
					end
				end
			end
			mcle_pkg::ST_EXEC: begin
				case (cmd_q)
					mcle_pkg::CMD_KEY: begin
						if (byte_q == mcle_pkg::KEY_KILL &&
						    ed_c != cm_c && mem_rdata != mcle_pkg::KEY_LF) begin
							// Erase one more character and fetch the one before it.
							ed_n      = dec_f(ed_c);
							upd       = 1'b1;
							cnt_d     = (cnt_q == mcle_pkg::ERASE_MAX) ? cnt_q
								    : cnt_q + 1'b1;
							mem_re    = 1'b1;
							mem_raddr = slot_f(cur_q, dec_f(dec_f(ed_c)));
						end else if (out_free) begin
							o_load  = 1'b1;
							state_d = mcle_pkg::ST_IDLE;
							case (byte_q) inside
								mcle_pkg::KEY_KILL: begin
									ec_d = cnt_q;
								end
								mcle_pkg::KEY_BS, mcle_pkg::KEY_DEL: begin
									if (ed_c != cm_c) begin
										ed_n = dec_f(ed_c);
										upd  = 1'b1;
										ec_d = 8'd1;
									end
								end
								mcle_pkg::KEY_NEXT: begin
									if (cur_q != CW'(CONSOLE_COUNT - 1)) begin
										cur_d = cur_q + 1'b1;
										sw_d  = 1'b1;
									end
								end
								mcle_pkg::KEY_PREV: begin
									if (cur_q != '0) begin
										cur_d = cur_q - 1'b1;
										sw_d  = 1'b1;
									end
								end
								mcle_pkg::KEY_DUMP, mcle_pkg::KEY_NUL: begin
								end
								default: begin
									// Store and echo when the ring has room.
									if (occ_c < DW'(BUFFER_DEPTH)) begin
										mem_we = 1'b1;
										ev_d   = 1'b1;
										eb_d   = store_c;
										ed_n   = ed_inc;
										upd    = 1'b1;
										if (store_c == mcle_pkg::KEY_LF ||
										    store_c == mcle_pkg::KEY_EOF ||
										    diff_f(ed_inc, rd_c) ==
										    DW'(BUFFER_DEPTH)) begin
											cm_n = ed_inc;
											lc_d = 1'b1;
										end
									end
								end
							endcase
						end
					end
					mcle_pkg::CMD_READ: begin
						if (out_free) begin
							o_load  = 1'b1;
							state_d = mcle_pkg::ST_IDLE;
							if (!con_ok_q || rd_c == cm_c) begin
								rs_d = mcle_pkg::RS_EMPTY;
							end else if (mem_rdata == mcle_pkg::KEY_EOF) begin
								// End of file is consumed only at the start of a call.
								rs_d = mcle_pkg::RS_EOF;
								if (first_q) begin
									rd_n = inc_f(rd_c);
									upd  = 1'b1;
								end
							end else begin
								rs_d = mcle_pkg::RS_DATA;
								rb_d = mem_rdata;
								le_d = (mem_rdata == mcle_pkg::KEY_LF);
								rd_n = inc_f(rd_c);
								upd  = 1'b1;
							end
						end
					end
					mcle_pkg::CMD_WRITE: begin
						if (out_free) begin
							o_load  = 1'b1;
							state_d = mcle_pkg::ST_IDLE;
							if (con_q == 4'(cur_q)) begin
								ev_d = 1'b1;
								eb_d = byte_q;
							end
						end
					end
					default: begin
						if (out_free) begin
							o_load  = 1'b1;
							state_d = mcle_pkg::ST_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = mcle_pkg::ST_IDLE;
			end
		endcase
	end

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Index registers and the active console.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONSOLE_COUNT; i++) begin
				read_idx_q[i]   <= '0;
				commit_idx_q[i] <= '0;
				edit_idx_q[i]   <= '0;
			end
			cur_q <= '0;
			cnt_q <= '0;
		end else begin
			cur_q <= cur_d;
			cnt_q <= accept ? '0 : cnt_d;
			if (upd) begin
				read_idx_q[sel]   <= rd_n;
				commit_idx_q[sel] <= cm_n;
				edit_idx_q[sel]   <= ed_n;
			end
		end
	end

	// Word captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= mcle_pkg::cmd_t'(cmd);
			byte_q   <= data_byte;
			con_q    <= console;
			con_ok_q <= con_ok_in;
			cidx_q   <= cidx_in;
			first_q  <= first_of_read;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (o_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (o_load) begin
			read_status_q    <= rs_d;
			read_byte_q      <= rb_d;
			line_end_q       <= le_d;
			echo_valid_q     <= ev_d;
			echo_byte_q      <= eb_d;
			erase_count_q    <= ec_d;
			line_committed_q <= lc_d;
			active_q         <= 4'(cur_d);
			switched_q       <= sw_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_status      = read_status_q;
	assign read_byte        = read_byte_q;
	assign line_end         = line_end_q;
	assign echo_valid       = echo_valid_q;
	assign echo_byte        = echo_byte_q;
	assign erase_count      = erase_count_q;
	assign line_committed   = line_committed_q;
	assign active_console   = active_q;
	assign console_switched = switched_q;

	// Checks on the controller and the ring indices.
	`MCLE_ASSERT_SAME(a_no_rw_clash, clk, arst_n, mem_we, !mem_re, "line store read and write in one cycle")
	`MCLE_ASSERT_SAME(a_ring_bound, clk, arst_n, state_q == mcle_pkg::ST_EXEC, occ_c <= DW'(BUFFER_DEPTH), "ring holds more than its depth")
	`MCLE_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == mcle_pkg::ST_EXEC && in_stall, "accepted word not executed")
	`MCLE_ASSERT_SAME(a_load_free, clk, arst_n, o_load, out_free, "result loaded over an untaken word")

endmodule
